// ===== design/sccc_pkg.sv =====
// package for the snooping cache controller: sizes, state codes, payload types
`timescale 1ns / 1ps
package sccc_pkg;
  localparam int SETS = 256;
  localparam int WAYS = 4;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS = 32;
  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(SETS);
  localparam int TAG_W = ADDR_BITS - OFF_W - SET_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;

  typedef enum logic [2:0] {
    ST_I = 3'd0, ST_S = 3'd1, ST_M = 3'd2, ST_E = 3'd3, ST_SC = 3'd4, ST_SM = 3'd5
  } line_state_t;

  typedef enum logic [1:0] {
    PROTO_MSI = 2'd0, PROTO_MESI = 2'd1, PROTO_DRAGON = 2'd2, PROTO_SPARE = 2'd3
  } proto_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0, PH_LOOKUP = 2'd1, PH_WRITE = 2'd2, PH_OUT = 2'd3
  } phase_t;

  typedef struct packed {
    logic        operation;
    logic        is_write;
    logic [31:0] address;
    logic        shared_line;
    logic        snoop_kind;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] state_after;
    logic       issue_read;
    logic       issue_read_exclusive;
    logic       issue_upgrade;
    logic       issue_update;
    logic       evict_writeback;
    logic       flush;
    logic       intervention;
    logic       invalidation;
    logic       cache_to_cache;
  } resp_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0]  tag;
    logic [WAYS-1:0][2:0]        st;
    logic [WAYS-1:0][RANK_W-1:0] rank;
  } set_row_t;
endpackage

// ===== design/snoopy_coherent_cache_controller.sv =====
// top level: snooping set-associative cache controller with msi, mesi and dragon
`timescale 1ns / 1ps
// timing: the set row is read, registered in row_q, and the result registered in resp before it
//   is offered; one item at a time, next item taken the cycle after the transfer out, and an
//   output stall holds the result in place
// set row memory: one read, modify, one write back per item, read data registered
// reset: synchronous; a clearing pass writes every set invalid with zero ranks; no item is
//   taken during it, protocol_select resets to msi
module snoopy_coherent_cache_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sccc_pkg::req_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sccc_pkg::resp_t       out_data
);
  localparam int SETS = sccc_pkg::SETS;
  localparam int WAYS = sccc_pkg::WAYS;
  localparam int SET_W = sccc_pkg::SET_W;
  localparam int TAG_W = sccc_pkg::TAG_W;
  localparam int RANK_W = sccc_pkg::RANK_W;
  localparam int WAY_W = sccc_pkg::WAY_W;
  localparam int OFF_W = sccc_pkg::OFF_W;

  sccc_pkg::set_row_t mem [SETS];
  sccc_pkg::set_row_t rd_row, new_row;
  logic [SET_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  sccc_pkg::set_row_t wr_row;

  logic [1:0]       protocol_select;
  sccc_pkg::phase_t phase, phase_next;
  logic [SET_W:0]   clr_cnt;
  logic             clearing;
  sccc_pkg::req_t   req;
  sccc_pkg::resp_t  resp, resp_next;
  sccc_pkg::set_row_t row_q;

  logic [SET_W-1:0] req_set;
  logic [TAG_W-1:0] req_tag;

  assign req_set = req.address[OFF_W +: SET_W];
  assign req_tag = req.address[OFF_W + SET_W +: TAG_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_select <= 2'd0;
    end else if (cfg_we) begin
      protocol_select <= cfg_wdata;
    end
  end

  assign clearing = !clr_cnt[SET_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sccc_pkg::PH_IDLE;
      clr_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      sccc_pkg::PH_IDLE:   if (!clearing && in_valid) phase_next = sccc_pkg::PH_LOOKUP;
      sccc_pkg::PH_LOOKUP: phase_next = sccc_pkg::PH_WRITE;
      sccc_pkg::PH_WRITE:  phase_next = sccc_pkg::PH_OUT;
      sccc_pkg::PH_OUT:    if (!out_stall) phase_next = sccc_pkg::PH_IDLE;
      default:             phase_next = sccc_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (phase != sccc_pkg::PH_IDLE) || clearing;
    out_valid = (phase == sccc_pkg::PH_OUT);
    out_data = resp;
    rd_addr = in_data.address[OFF_W +: SET_W];
    wr_en = 1'b0;
    wr_addr = req_set;
    wr_row = new_row;
    if (clearing) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[SET_W-1:0];
      wr_row = '0;
    end else if (phase == sccc_pkg::PH_WRITE) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == sccc_pkg::PH_IDLE && !in_stall && in_valid) begin
      req <= in_data;
    end
    if (phase == sccc_pkg::PH_LOOKUP) begin
      row_q <= rd_row;
    end
    if (phase == sccc_pkg::PH_WRITE) begin
      resp <= resp_next;
    end
  end

  // lookup, victim choice, state update and lru on the registered row
  logic [WAY_W-1:0]  hw, vw, w;
  logic              hit, found_inv, wb;
  logic [RANK_W-1:0] best, r;
  logic [2:0]        st, ns;
  sccc_pkg::proto_t  proto;
  logic              touch;

  always_comb begin
    hw = '0;
    hit = 1'b0;
    best = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (row_q.st[j] != sccc_pkg::ST_I && row_q.tag[j] == req_tag) begin
        hit = 1'b1;
        hw = WAY_W'(j);
      end
    end
    vw = '0;
    found_inv = 1'b0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (row_q.st[j] == sccc_pkg::ST_I) begin
        found_inv = 1'b1;
        vw = WAY_W'(j);
      end
    end
    if (!found_inv) begin
      for (int j = 0; j < WAYS; j++) begin
        if (row_q.rank[j] >= best) begin
          best = row_q.rank[j];
          vw = WAY_W'(j);
        end
      end
    end
  end

  always_comb begin
    proto = sccc_pkg::proto_t'(protocol_select);
    if (proto == sccc_pkg::PROTO_SPARE) proto = sccc_pkg::PROTO_MSI;
    resp_next = '0;
    new_row = row_q;
    w = hit ? hw : vw;
    st = hit ? row_q.st[hw] : sccc_pkg::ST_I;
    ns = st;
    wb = 1'b0;
    touch = !req.operation;
    if (!req.operation) begin
      if (!hit) begin
        wb = row_q.st[vw] == sccc_pkg::ST_M || row_q.st[vw] == sccc_pkg::ST_SM;
        new_row.tag[vw] = req_tag;
        unique case (proto)
          sccc_pkg::PROTO_MESI: begin
            resp_next.issue_read = !req.is_write;
            resp_next.issue_read_exclusive = req.is_write;
            resp_next.cache_to_cache = req.shared_line;
            ns = req.is_write ? sccc_pkg::ST_M
               : (req.shared_line ? sccc_pkg::ST_S : sccc_pkg::ST_E);
          end
          sccc_pkg::PROTO_DRAGON: begin
            resp_next.issue_read = 1'b1;
            resp_next.issue_update = req.is_write && req.shared_line;
            if (req.is_write) ns = req.shared_line ? sccc_pkg::ST_SM : sccc_pkg::ST_M;
            else ns = req.shared_line ? sccc_pkg::ST_SC : sccc_pkg::ST_E;
          end
          default: begin
            resp_next.issue_read = !req.is_write;
            resp_next.issue_read_exclusive = req.is_write;
            ns = req.is_write ? sccc_pkg::ST_M : sccc_pkg::ST_S;
          end
        endcase
      end else if (req.is_write) begin
        unique case (proto)
          sccc_pkg::PROTO_MESI: begin
            if (st == sccc_pkg::ST_E) ns = sccc_pkg::ST_M;
            else if (st == sccc_pkg::ST_S) begin
              ns = sccc_pkg::ST_M;
              resp_next.issue_upgrade = 1'b1;
            end
          end
          sccc_pkg::PROTO_DRAGON: begin
            if (st == sccc_pkg::ST_E) ns = sccc_pkg::ST_M;
            else if (st == sccc_pkg::ST_SM || st == sccc_pkg::ST_SC) begin
              ns = req.shared_line ? sccc_pkg::ST_SM : sccc_pkg::ST_M;
              resp_next.issue_update = 1'b1;
            end
          end
          default: begin
            if (st == sccc_pkg::ST_S) begin
              ns = sccc_pkg::ST_M;
              resp_next.issue_read_exclusive = 1'b1;
            end
          end
        endcase
      end
      new_row.st[w] = ns;
    end else if (hit) begin
      if (proto != sccc_pkg::PROTO_DRAGON) begin
        if (st == sccc_pkg::ST_M) begin
          resp_next.flush = 1'b1;
          ns = req.is_write ? sccc_pkg::ST_I : sccc_pkg::ST_S;
          resp_next.invalidation = req.is_write;
          resp_next.intervention = !req.is_write;
        end else if (st == sccc_pkg::ST_S) begin
          if (req.is_write) begin
            ns = sccc_pkg::ST_I;
            resp_next.invalidation = 1'b1;
          end
        end else if (st == sccc_pkg::ST_E && proto == sccc_pkg::PROTO_MESI) begin
          ns = req.is_write ? sccc_pkg::ST_I : sccc_pkg::ST_S;
          resp_next.invalidation = req.is_write;
          resp_next.intervention = !req.is_write;
        end
      end else if (!req.snoop_kind) begin
        if (st == sccc_pkg::ST_E) begin
          ns = sccc_pkg::ST_SC;
          resp_next.intervention = 1'b1;
        end else if (st == sccc_pkg::ST_M) begin
          ns = sccc_pkg::ST_SM;
          resp_next.intervention = 1'b1;
          resp_next.flush = 1'b1;
        end else if (st == sccc_pkg::ST_SM) begin
          resp_next.flush = 1'b1;
        end
      end else if (st == sccc_pkg::ST_SM) begin
        ns = sccc_pkg::ST_SC;
      end
      new_row.st[w] = ns;
    end
    if (touch) begin
      r = row_q.rank[w];
      for (int j = 0; j < WAYS; j++) begin
        if (WAY_W'(j) != w && row_q.rank[j] <= r && row_q.rank[j] < RANK_W'(WAYS - 1)) begin
          new_row.rank[j] = row_q.rank[j] + 1'b1;
        end
      end
      new_row.rank[w] = '0;
    end else begin
      r = '0;
    end
    resp_next.hit = hit;
    resp_next.state_after = ns;
    resp_next.evict_writeback = wb;
  end

`ifndef NO_ASSERTIONS
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> phase == sccc_pkg::PH_IDLE) else $error("item taken during clear");
  a_out_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(phase) == sccc_pkg::PH_WRITE) else $error("bad out timing");
  a_snoop_no_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && req.operation |-> !out_data.issue_read && !out_data.issue_read_exclusive
      && !out_data.evict_writeback) else $error("snoop issued bus command");
  a_proc_no_snoop_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !req.operation |-> !out_data.flush && !out_data.invalidation
      && !out_data.intervention) else $error("access raised snoop flag");
`endif
endmodule
